// ===== rtl/core/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and codes for the column-to-row compressed scatter block.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_DEGREE  = 2'd0,
    OP_NONZERO = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_ROW_PTR = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_CLEARED = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNLOADED = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  row;
    logic [9:0]  column;
    logic [10:0] degree;
  } csc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] position;
    logic [9:0]  placed_column;
    logic [16:0] row_start;
    logic [1:0]  status;
  } csc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } csc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
  } csc_sts_t;

endpackage

// ===== rtl/core/csc_ram.sv =====
// ----------------------------------------------------------------------------
// csc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/csc_ctrl.sv =====
// ----------------------------------------------------------------------------
// csc_ctrl
// Controller: sequences accept, execute and result hand-off.
// ----------------------------------------------------------------------------
module csc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csc_pkg::csc_cmd_t cmd_o,
  input  csc_pkg::csc_sts_t sts_i
);
  import csc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, commit;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // Commit only when the output register is free or draining this cycle
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (commit && sts_i.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.commit  = commit;

endmodule

// ===== rtl/core/csc_datapath.sv =====
// ----------------------------------------------------------------------------
// csc_datapath
// Datapath: prefix sum, row count, row cursor memory and result register.
// ----------------------------------------------------------------------------
module csc_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csc_pkg::csc_in_t  in_req_i,
  input  csc_pkg::csc_cmd_t cmd_i,
  output csc_pkg::csc_sts_t sts_o,
  output csc_pkg::csc_out_t out_rsp_o
);
  import csc_pkg::*;

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int LW   = $clog2(MAX_VERTICES + 1);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int NW   = ((CW > 11) ? CW : 11) + 1;
  localparam int CMPW = (LW > 10) ? LW : 10;

  csc_in_t        item_q;
  logic [CW-1:0]  sum_q, sum_d;
  logic [LW-1:0]  loaded_q, loaded_d;
  csc_out_t       out_q, out_d;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [CW-1:0]  wdata;
  logic [CW-1:0]  slot;

  logic [NW-1:0]  sum_ext;
  logic           rows_full;
  logic           row_ok;
  logic           slot_ok;

  csc_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_VERTICES)
  ) u_cursor_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (AW'(in_req_i.row)),
    .rdata_o (slot)
  );

  assign sum_ext   = NW'(sum_q) + NW'(item_q.degree);
  assign rows_full = (loaded_q >= LW'(MAX_VERTICES));
  assign row_ok    = (CMPW'(item_q.row) < CMPW'(loaded_q));
  assign slot_ok   = (slot < CW'(MAX_EDGES));

  assign sts_o.has_result = (item_q.op == OP_DEGREE) || (item_q.op == OP_NONZERO) ||
                            (item_q.op == OP_CLEAR);

  always_comb begin
    sum_d    = sum_q;
    loaded_d = loaded_q;
    out_d    = '0;
    we       = 1'b0;
    waddr    = AW'(loaded_q);
    wdata    = sum_q;
    unique case (item_q.op)
      OP_DEGREE: begin
        out_d.kind      = KIND_ROW_PTR;
        out_d.row_start = 17'(sum_q);
        if (rows_full) begin
          out_d.status = ST_OVERFLOW;
        end else begin
          we       = 1'b1;
          loaded_d = loaded_q + LW'(1);
          // Saturate the prefix sum at the edge store size
          if (sum_ext > NW'(MAX_EDGES)) begin
            sum_d        = CW'(MAX_EDGES);
            out_d.status = ST_OVERFLOW;
          end else begin
            sum_d = CW'(sum_ext);
          end
        end
      end
      OP_NONZERO: begin
        out_d.kind = KIND_NONZERO;
        waddr      = AW'(item_q.row);
        wdata      = slot + CW'(1);
        priority if (!row_ok) begin
          out_d.status = ST_UNLOADED;
        end else if (!slot_ok) begin
          out_d.status = ST_OVERFLOW;
        end else begin
          we                  = 1'b1;
          out_d.position      = 16'(slot);
          out_d.placed_column = item_q.column;
        end
      end
      OP_CLEAR: begin
        out_d.kind = KIND_CLEARED;
        sum_d      = '0;
        loaded_d   = '0;
      end
      default: begin
        // unused op: drop silently
      end
    endcase
    we = we && cmd_i.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      loaded_q <= '0;
    end else if (cmd_i.commit) begin
      sum_q    <= sum_d;
      loaded_q <= loaded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_req_i;
    end
    if (cmd_i.commit && sts_o.has_result) begin
      out_q <= out_d;
    end
  end

  assign out_rsp_o = out_q;

endmodule

// ===== rtl/core/csc_to_csr_scatter.sv =====
// A request is registered and its row cursor read when it is accepted; its
// result is registered when it commits, held back while the previous result
// waits in the output register. Cursor read and write-back keep a new
// request out until the current one commits. A waiting result holds the
// next request in execution, so acceptance stops after it until it drains.
// Reset clears the prefix sum, row count and output valid; the cursor memory
// keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// csc_to_csr_scatter
// Column-compressed to row-compressed scatter: row pointers and placements.
// ----------------------------------------------------------------------------
module csc_to_csr_scatter #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csc_pkg::csc_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csc_pkg::csc_out_t out_rsp_o
);
  import csc_pkg::*;

  csc_cmd_t cmd;
  csc_sts_t sts;

  csc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// ===== rtl/core/csc_checker.sv =====
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the scatter block, bound to the top level.
// ----------------------------------------------------------------------------
module csc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input csc_pkg::csc_in_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input csc_pkg::csc_out_t out_rsp_o
);
  import csc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or dropped");

  // Hold a waiting request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("waiting request changed or dropped");

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Row start appears on row pointer results only
  a_row_start_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.kind != KIND_ROW_PTR) |-> (out_rsp_o.row_start == '0))
    else $error("row start on a non-pointer result");

  // Unloaded row status only on a placement, with no slot
  a_unloaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_UNLOADED) |->
      (out_rsp_o.kind == KIND_NONZERO) && (out_rsp_o.position == '0) &&
      (out_rsp_o.placed_column == '0))
    else $error("bad unloaded-row result");

endmodule

bind csc_to_csr_scatter csc_checker u_csc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the column-to-row compressed scatter block.
// A short table of hand-picked requests comes first: loads at the degree
// extremes, placements, unloaded rows, clears and the unused opcode. Random
// matrices follow as degree loads and then shuffled nonzeros, with stray
// requests mixed in, plus a store-saturation run. Each accepted request goes
// through a local model of the cursor/prefix-sum state. Each result is
// checked in order against the table's expected result where one is given,
// else against the model. Both sides stall at random, and the receiver
// holds off once for a long stretch.
module tb_top;
  import csc_pkg::*;

  localparam int unsigned ROWS_MAX  = 1024;
  localparam int unsigned SLOTS_MAX = 65536;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  typedef struct packed {
    logic     given;
    csc_out_t val;
  } typed_rsp_t;

  typedef struct packed {
    csc_in_t    req;
    typed_rsp_t want;
  } dir_row_t;

  localparam typed_rsp_t NO_TABLE_RSP = '0;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  csc_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  csc_out_t out_rsp_o;

  // Model state
  logic [16:0] cursor_model [ROWS_MAX];
  logic [16:0] prefix_sum = '0;
  logic [10:0] rows_in    = '0;

  typed_rsp_t  table_rsp_q[$];
  csc_out_t    expected_rsp_q[$];

  int unsigned reqs_taken   = 0;
  int unsigned rsp_checked  = 0;
  int unsigned errors       = 0;
  int unsigned n_row_ptr    = 0;
  int unsigned n_placed     = 0;
  int unsigned n_cleared    = 0;
  int unsigned n_overflow   = 0;
  int unsigned n_unloaded   = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  csc_to_csr_scatter #(
    .MAX_VERTICES(ROWS_MAX),
    .MAX_EDGES   (SLOTS_MAX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advance the cursor/prefix-sum model by one request; returns 1 when the
  // request produces a result.
  function automatic bit predict_scatter(input csc_in_t req, output csc_out_t rsp);
    logic [17:0] next_sum;
    logic [16:0] slot;
    rsp = '0;
    case (req.op)
      OP_DEGREE: begin
        rsp.kind      = KIND_ROW_PTR;
        rsp.row_start = prefix_sum;
        if (rows_in >= ROWS_MAX) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          next_sum = 18'(prefix_sum) + 18'(req.degree);
          if (next_sum > SLOTS_MAX) begin
            next_sum   = 18'(SLOTS_MAX);
            rsp.status = ST_OVERFLOW;
          end
          cursor_model[rows_in[9:0]] = prefix_sum;
          rows_in    = rows_in + 11'd1;
          prefix_sum = next_sum[16:0];
        end
        return 1'b1;
      end
      OP_NONZERO: begin
        rsp.kind = KIND_NONZERO;
        if ({1'b0, req.row} >= rows_in) begin
          rsp.status = ST_UNLOADED;
          return 1'b1;
        end
        slot = cursor_model[req.row];
        if (slot >= SLOTS_MAX) begin
          rsp.status = ST_OVERFLOW;
          return 1'b1;
        end
        cursor_model[req.row] = slot + 17'd1;
        rsp.position          = slot[15:0];
        rsp.placed_column     = req.column;
        return 1'b1;
      end
      OP_CLEAR: begin
        prefix_sum = '0;
        rows_in    = '0;
        rsp.kind   = KIND_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic csc_in_t rq(input logic [1:0] op, input int unsigned row,
                                 input int unsigned col, input int unsigned deg);
    csc_in_t q;
    q.op     = op;
    q.row    = 10'(row);
    q.column = 10'(col);
    q.degree = 11'(deg);
    return q;
  endfunction

  function automatic typed_rsp_t rs(input logic [1:0] kind, input int unsigned pos,
                                    input int unsigned col, input int unsigned start,
                                    input logic [1:0] status);
    typed_rsp_t t;
    t.given             = 1'b1;
    t.val.kind          = kind;
    t.val.position      = 16'(pos);
    t.val.placed_column = 10'(col);
    t.val.row_start     = 17'(start);
    t.val.status        = status;
    return t;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic drive(input csc_in_t q, input typed_rsp_t want);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    table_rsp_q.push_back(want);
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Fields the opcode ignores carry random values.
  task automatic put(input logic [1:0] op, input int unsigned row,
                     input int unsigned col, input int unsigned deg);
    csc_in_t q;
    q = rq(op, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 2047));
    if (op == OP_NONZERO) begin
      q.row    = 10'(row);
      q.column = 10'(col);
    end
    if (op == OP_DEGREE) q.degree = 11'(deg);
    drive(q, NO_TABLE_RSP);
  endtask

  // Load a random matrix row by row, then scatter its nonzeros in shuffled
  // order with stray requests mixed in.
  task automatic scatter_matrix(input int unsigned nrows, input int unsigned maxdeg);
    int unsigned pend[$];
    int unsigned r;
    int unsigned deg;
    int unsigned pick;
    int unsigned col;
    put(OP_CLEAR, 0, 0, 0);
    for (r = 0; r < nrows; r++) begin
      deg = $urandom_range(0, maxdeg);
      put(OP_DEGREE, 0, 0, deg);
      repeat (deg) pend.push_back(r);
    end
    col = 0;
    while (pend.size() != 0) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       put(OP_UNUSED, 0, 0, 0);
          1:       put(OP_NONZERO, $urandom_range(nrows, 1023), $urandom_range(0, 1023), 0);
          2:       put(OP_NONZERO, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
          default: put(OP_DEGREE, 0, 0, $urandom_range(0, 2047));
        endcase
      end
      pick = $urandom_range(0, pend.size() - 1);
      put(OP_NONZERO, pend[pick], col, 0);
      pend.delete(pick);
      col = (col + $urandom_range(0, 3)) % 1024;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    typed_rsp_t hint;
    csc_out_t   want;
    csc_out_t   model_rsp;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        hint = table_rsp_q.pop_front();
        reqs_taken++;
        if (predict_scatter(in_req_i, model_rsp)) begin
          expected_rsp_q.push_back(hint.given ? hint.val : model_rsp);
        end
      end
      if (out_valid_o && out_ready_i) begin
        rsp_checked++;
        if (expected_rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h at %0t", out_rsp_o, $realtime);
        end else begin
          want = expected_rsp_q.pop_front();
          case (want.kind)
            KIND_ROW_PTR: n_row_ptr++;
            KIND_NONZERO: n_placed++;
            default:      n_cleared++;
          endcase
          if (want.status == ST_OVERFLOW) n_overflow++;
          if (want.status == ST_UNLOADED) n_unloaded++;
          if (out_rsp_o.kind !== want.kind || out_rsp_o.position !== want.position ||
              out_rsp_o.placed_column !== want.placed_column ||
              out_rsp_o.row_start !== want.row_start || out_rsp_o.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t (expected / actual):", $realtime);
              $display("  kind %0d / %0d  position %0d / %0d  column %0d / %0d",
                       want.kind, out_rsp_o.kind, want.position, out_rsp_o.position,
                       want.placed_column, out_rsp_o.placed_column);
              $display("  row_start %0d / %0d  status %0d / %0d",
                       want.row_start, out_rsp_o.row_start, want.status, out_rsp_o.status);
            end
          end
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches and one long hold-off.
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (taken == 200) stall = 400;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : sender
    dir_row_t    dir_tab[$];
    int unsigned k;

    dir_tab.push_back({rq(OP_NONZERO, 0, 5, 0), rs(KIND_NONZERO, 0, 0, 0, ST_UNLOADED)});
    dir_tab.push_back({rq(OP_UNUSED, 0, 0, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_DEGREE, 0, 0, 0), rs(KIND_ROW_PTR, 0, 0, 0, ST_OK)});
    dir_tab.push_back({rq(OP_DEGREE, 0, 0, 1024), rs(KIND_ROW_PTR, 0, 0, 0, ST_OK)});
    dir_tab.push_back({rq(OP_DEGREE, 0, 0, 1024), rs(KIND_ROW_PTR, 0, 0, 1024, ST_OK)});
    dir_tab.push_back({rq(OP_DEGREE, 1023, 1023, 1), rs(KIND_ROW_PTR, 0, 0, 2048, ST_OK)});
    dir_tab.push_back({rq(OP_NONZERO, 1, 1023, 0), rs(KIND_NONZERO, 0, 1023, 0, ST_OK)});
    dir_tab.push_back({rq(OP_NONZERO, 1, 0, 2047), NO_TABLE_RSP});
    // row 0 has no entries: its cursor runs into row 1's slots
    dir_tab.push_back({rq(OP_NONZERO, 0, 7, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_NONZERO, 3, 512, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_NONZERO, 3, 1, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_NONZERO, 4, 0, 0), rs(KIND_NONZERO, 0, 0, 0, ST_UNLOADED)});
    dir_tab.push_back({rq(OP_NONZERO, 1023, 1023, 0),
                       rs(KIND_NONZERO, 0, 0, 0, ST_UNLOADED)});
    dir_tab.push_back({rq(OP_UNUSED, 1023, 1023, 2047), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_CLEAR, 1023, 1023, 2047), rs(KIND_CLEARED, 0, 0, 0, ST_OK)});
    dir_tab.push_back({rq(OP_NONZERO, 0, 9, 0), rs(KIND_NONZERO, 0, 0, 0, ST_UNLOADED)});
    dir_tab.push_back({rq(OP_DEGREE, 0, 0, 2047), rs(KIND_ROW_PTR, 0, 0, 0, ST_OK)});
    dir_tab.push_back({rq(OP_DEGREE, 682, 341, 5), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_NONZERO, 0, 341, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_NONZERO, 1, 682, 0), NO_TABLE_RSP});
    dir_tab.push_back({rq(OP_CLEAR, 0, 0, 0), rs(KIND_CLEARED, 0, 0, 0, ST_OK)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_tab.size(); k++) drive(dir_tab[k].req, dir_tab[k].want);

    repeat (3) scatter_matrix($urandom_range(2, 30), $urandom_range(0, 8));

    // Saturate the store: the prefix sum lands on 65535, the next row
    // starts there and later rows start at the saturated limit.
    put(OP_CLEAR, 0, 0, 0);
    repeat (63) put(OP_DEGREE, 0, 0, 1024);
    put(OP_DEGREE, 0, 0, 1023);
    put(OP_DEGREE, 0, 0, 1);
    repeat (6) put(OP_DEGREE, 0, 0, $urandom_range(0, 2047));
    put(OP_NONZERO, 64, 1023, 0);
    put(OP_NONZERO, 64, 0, 0);
    put(OP_NONZERO, 65, 17, 0);
    repeat (40) put(OP_NONZERO, $urandom_range(0, 75), $urandom_range(0, 1023), 0);

    scatter_matrix($urandom_range(2, 30), $urandom_range(0, 8));

    repeat (5) scatter_matrix($urandom_range(2, 30), $urandom_range(0, 8));
    put(OP_CLEAR, 0, 0, 0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    errors += expected_rsp_q.size();

    $display("Run covered %0d requests and %0d results: %0d row pointers, %0d placements,",
             reqs_taken, rsp_checked, n_row_ptr, n_placed);
    $display("%0d clears, %0d overflow flags and %0d unloaded-row flags; %0d errors.",
             n_cleared, n_overflow, n_unloaded, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
